/* rtl/core/positional_insert_queue_macros.svh */
// ----------------------------------------------------------------------------
// positional_insert_queue_macros
// assertion shorthands for the queue rtl
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_INSERT_QUEUE_MACROS_SVH
`define POSITIONAL_INSERT_QUEUE_MACROS_SVH

// same-cycle implication, clocked on i_clk, off while in reset
`define PIQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off while in reset
`define PIQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/piq_pkg.sv */
// ----------------------------------------------------------------------------
// piq_pkg
// request and result codes, sequencer states and fixed port widths
// ----------------------------------------------------------------------------
package piq_pkg;

    localparam int REQ_W      = 2;
    localparam int POS_W      = 8;
    localparam int CODE_W     = 2;
    localparam int PORT_TAG_W = 32;

    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STATUS = 2'd2;

    localparam logic [CODE_W-1:0] RC_OK    = 2'd0;
    localparam logic [CODE_W-1:0] RC_FULL  = 2'd1;
    localparam logic [CODE_W-1:0] RC_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_WR,
        S_INS_WR,
        S_HEAD_RD,
        S_HEAD_CAP,
        S_DN_RD,
        S_DN_WR,
        S_RM_DONE,
        S_ST_RD,
        S_ST_OUT
    } t_state;

endpackage

/* rtl/core/positional_insert_queue.sv */
// ----------------------------------------------------------------------------
// positional_insert_queue
// bounded ordered tag queue with insert at position, head removal and readout
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low. Every result
// beat shows on the o_ result ports for exactly one cycle with o_strobe high,
// and the receiver cannot stall it, so each beat must be captured when seen.
// The tags live in a single memory (one write, one registered read per cycle)
// with the head at cell 0; a small sequencer moves entries through that one
// port pair, each moved entry read, then written. An add to a full queue,
// a remove or status on an empty queue and an unused request code finish at
// once with busy low; all but the unused code give a result in the next
// cycle. An add shifts the entries from the insert index on toward the tail
// and writes the new tag; a remove reads the head and pulls each later entry
// forward; both give the result in the cycle after busy falls.
// A status readout gives a beat per entry, the last marked by o_last_of_run.
// No clearing after reset: cells at or past the count never reach a result.
// ----------------------------------------------------------------------------
`include "positional_insert_queue_macros.svh"

module positional_insert_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_WIDTH   = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [piq_pkg::REQ_W-1:0]           i_req_type,
    input  logic [piq_pkg::PORT_TAG_W-1:0]      i_item_tag,
    input  logic [piq_pkg::POS_W-1:0]           i_insert_position,
    output logic                                o_strobe,
    output logic [piq_pkg::PORT_TAG_W-1:0]      o_entry_tag,
    output logic                                o_entry_valid,
    output logic                                o_last_of_run,
    output logic [piq_pkg::CODE_W-1:0]          o_result_code
);

    import piq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // sequencer and queue state
    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [IDX_W-1:0]       r_ptr, n_ptr;
    logic [IDX_W-1:0]       r_at, n_at;
    logic [TAG_WIDTH-1:0]   r_tag, n_tag;
    logic [TAG_WIDTH-1:0]   r_head, n_head;

    // registered result beat
    logic                   r_strobe, n_strobe;
    logic [PORT_TAG_W-1:0]  r_entry_tag, n_entry_tag;
    logic                   r_entry_valid, n_entry_valid;
    logic                   r_last, n_last;
    logic [CODE_W-1:0]      r_code, n_code;

    // tag memory, one write and one registered read port
    logic [TAG_WIDTH-1:0]   r_mem [QUEUE_DEPTH];
    logic [TAG_WIDTH-1:0]   r_rd_data;
    logic [IDX_W-1:0]       mem_rd_addr;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_wr_addr;
    logic [TAG_WIDTH-1:0]   mem_wr_data;

    logic                   accept;
    logic                   is_full;
    logic                   is_empty;
    logic [POS_W-1:0]       pos_m1;
    logic                   pos_clamp;
    logic [IDX_W-1:0]       ins_at;
    logic [TAG_WIDTH-1:0]   tag_in;
    logic [TAG_WIDTH-1:0]   out_tag;
    logic [PORT_TAG_W-1:0]  out_tag_port;
    logic                   st_last;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign is_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign is_empty = (r_count == '0);

    // insert index: position 0 or any index at or past the count appends at the tail
    assign pos_m1    = i_insert_position - POS_W'(1);
    assign pos_clamp = (i_insert_position == '0) || (pos_m1 >= POS_W'(r_count));
    assign ins_at    = pos_clamp ? r_count[IDX_W-1:0] : pos_m1[IDX_W-1:0];

    // status readout: last entry when the pointer reaches count - 1
    assign st_last = ((CNT_W'(r_ptr) + CNT_W'(1)) == r_count);

    // removed head or streamed entry feeds the result tag
    assign out_tag = (r_state == S_RM_DONE) ? r_head : r_rd_data;

    // tag width against the fixed 32-bit port
    generate
        if (TAG_WIDTH == PORT_TAG_W) begin : g_tag_eq
            assign tag_in       = i_item_tag;
            assign out_tag_port = out_tag;
        end else if (TAG_WIDTH > PORT_TAG_W) begin : g_tag_wide
            assign tag_in       = {{(TAG_WIDTH-PORT_TAG_W){1'b0}}, i_item_tag};
            assign out_tag_port = out_tag[PORT_TAG_W-1:0];
        end else begin : g_tag_narrow
            assign tag_in       = i_item_tag[TAG_WIDTH-1:0];
            assign out_tag_port = {{(PORT_TAG_W-TAG_WIDTH){1'b0}}, out_tag};
        end
    endgenerate

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_req_type)
                        REQ_ADD: begin
                            if (!is_full) begin
                                n_state = (CNT_W'(ins_at) == r_count) ? S_INS_WR : S_UP_RD;
                            end
                        end
                        REQ_REMOVE: begin
                            if (!is_empty) begin
                                n_state = S_HEAD_RD;
                            end
                        end
                        REQ_STATUS: begin
                            if (!is_empty) begin
                                n_state = S_ST_RD;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            // shift toward the tail, from the last entry down to the insert index
            S_UP_RD:    n_state = S_UP_WR;
            S_UP_WR:    n_state = ((r_ptr - IDX_W'(1)) == r_at) ? S_INS_WR : S_UP_RD;
            S_INS_WR:   n_state = S_IDLE;
            // read the head, then pull every later entry forward
            S_HEAD_RD:  n_state = S_HEAD_CAP;
            S_HEAD_CAP: n_state = (r_count == CNT_W'(1)) ? S_RM_DONE : S_DN_RD;
            S_DN_RD:    n_state = S_DN_WR;
            S_DN_WR:    n_state = ((CNT_W'(r_ptr) + CNT_W'(2)) == r_count) ?
                                  S_RM_DONE : S_DN_RD;
            S_RM_DONE:  n_state = S_IDLE;
            // each readout beat: read the entry, then show it
            S_ST_RD:    n_state = S_ST_OUT;
            S_ST_OUT:   n_state = st_last ? S_IDLE : S_ST_RD;
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs, memory control and datapath updates
    always_comb begin
        n_count       = r_count;
        n_ptr         = r_ptr;
        n_at          = r_at;
        n_tag         = r_tag;
        n_head        = r_head;
        n_strobe      = 1'b0;
        n_entry_tag   = '0;
        n_entry_valid = 1'b0;
        n_last        = 1'b0;
        n_code        = RC_OK;
        mem_rd_addr   = r_ptr;
        mem_we        = 1'b0;
        mem_wr_addr   = r_ptr;
        mem_wr_data   = r_rd_data;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_req_type) inside
                        REQ_ADD: begin
                            if (is_full) begin
                                n_strobe = 1'b1;
                                n_last   = 1'b1;
                                n_code   = RC_FULL;
                            end else begin
                                n_tag = tag_in;
                                n_at  = ins_at;
                                n_ptr = r_count[IDX_W-1:0];
                            end
                        end
                        REQ_REMOVE, REQ_STATUS: begin
                            if (is_empty) begin
                                n_strobe = 1'b1;
                                n_last   = 1'b1;
                                n_code   = RC_EMPTY;
                            end else begin
                                n_ptr = '0;
                            end
                        end
                        default: n_ptr = r_ptr;
                    endcase
                end
            end
            S_UP_RD: begin
                mem_rd_addr = r_ptr - IDX_W'(1);
            end
            S_UP_WR: begin
                mem_we      = 1'b1;
                mem_wr_addr = r_ptr;
                mem_wr_data = r_rd_data;
                n_ptr       = r_ptr - IDX_W'(1);
            end
            S_INS_WR: begin
                mem_we      = 1'b1;
                mem_wr_addr = r_at;
                mem_wr_data = r_tag;
                n_count     = r_count + CNT_W'(1);
                n_strobe    = 1'b1;
                n_last      = 1'b1;
            end
            S_HEAD_RD: begin
                mem_rd_addr = '0;
            end
            S_HEAD_CAP: begin
                n_head = r_rd_data;
            end
            S_DN_RD: begin
                mem_rd_addr = r_ptr + IDX_W'(1);
            end
            S_DN_WR: begin
                mem_we      = 1'b1;
                mem_wr_addr = r_ptr;
                mem_wr_data = r_rd_data;
                n_ptr       = r_ptr + IDX_W'(1);
            end
            S_RM_DONE: begin
                n_count       = r_count - CNT_W'(1);
                n_strobe      = 1'b1;
                n_entry_tag   = out_tag_port;
                n_entry_valid = 1'b1;
                n_last        = 1'b1;
            end
            S_ST_RD: begin
                mem_rd_addr = r_ptr;
            end
            S_ST_OUT: begin
                n_strobe      = 1'b1;
                n_entry_tag   = out_tag_port;
                n_entry_valid = 1'b1;
                n_last        = st_last;
                n_ptr         = r_ptr + IDX_W'(1);
            end
            default: n_ptr = r_ptr;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ptr         <= n_ptr;
        r_at          <= n_at;
        r_tag         <= n_tag;
        r_head        <= n_head;
        r_entry_tag   <= n_entry_tag;
        r_entry_valid <= n_entry_valid;
        r_last        <= n_last;
        r_code        <= n_code;
    end

    // tag memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wr_addr] <= mem_wr_data;
        end
        r_rd_data <= r_mem[mem_rd_addr];
    end

    assign o_strobe      = r_strobe;
    assign o_entry_tag   = r_entry_tag;
    assign o_entry_valid = r_entry_valid;
    assign o_last_of_run = r_last;
    assign o_result_code = r_code;

    // checks
    `PIQ_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_W'(QUEUE_DEPTH),
        "entry count beyond queue depth")
    `PIQ_ASSERT_IMP(a_valid_ok, o_strobe && o_entry_valid, o_result_code == RC_OK,
        "valid entry beat with an error code")
    `PIQ_ASSERT_NXT(a_ins_count, r_state == S_INS_WR, r_count == $past(r_count) + CNT_W'(1),
        "insert did not grow the count")
    `PIQ_ASSERT_NXT(a_empty_remove, accept && is_empty && (i_req_type == REQ_REMOVE),
        o_strobe && o_last_of_run && (o_result_code == RC_EMPTY),
        "remove on empty queue not flagged")
    `PIQ_ASSERT_IMP(a_st_ptr, r_state == S_ST_RD || r_state == S_ST_OUT,
        CNT_W'(r_ptr) < r_count, "readout pointer past the count")

endmodule

/* bench/tb_positional_insert_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_insert_queue
// self-checking bench for the positional insert queue
// ----------------------------------------------------------------------------
// Request beats go in on the start/busy handshake. A scoreboard keeps its own
// copy of the queue, works out the result beats of every accepted request
// and checks each strobed result beat against the oldest one still waiting.
// A short directed run covers the empty and full corners, head, middle and
// clamped inserts and the unused request code. Random traffic follows, in
// fill and drain phases so that the queue swings between empty and full.
// ----------------------------------------------------------------------------
module tb_positional_insert_queue;

    import piq_pkg::*;

    localparam int          DEPTH         = 16;
    localparam int          RANDOM_BEATS  = 190;
    localparam int          QUIET_TAIL    = 40;     // last beats sent with no gaps
    localparam int          DRAIN_CYCLES  = 40;     // outlasts the longest busy stretch
    localparam int          LIMIT_CYCLES  = 200000;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3; // decoded as a no-op

    // one expected result beat
    typedef struct packed {
        logic [PORT_TAG_W-1:0] tag;
        logic                  valid;
        logic                  last;
        logic [CODE_W-1:0]     code;
    } t_result_beat;

    // ------------------------------------------------------------------------
    // scoreboard: shadow copy of the queue plus the beats still owed
    // ------------------------------------------------------------------------
    class tag_queue_scoreboard;
        logic [PORT_TAG_W-1:0] shadow_tags[$];
        t_result_beat          owed_beats[$];
        int                    mismatch_count = 0;

        function int stored_count();
            return shadow_tags.size();
        endfunction

        function int owed_count();
            return owed_beats.size();
        endfunction

        task report_mismatch(input string what);
            mismatch_count++;
            $display("[%0t] error: %s", $realtime, what);
        endtask

        function void owe(input logic [PORT_TAG_W-1:0] tag, input logic valid,
                          input logic last, input logic [CODE_W-1:0] code);
            t_result_beat b;
            b.tag   = tag;
            b.valid = valid;
            b.last  = last;
            b.code  = code;
            owed_beats.push_back(b);
        endfunction

        // predict the beats of one accepted request and update the shadow queue
        function void note_request(input logic [REQ_W-1:0] req,
                                   input logic [PORT_TAG_W-1:0] tag,
                                   input logic [POS_W-1:0] pos);
            int n;
            int at;
            n = shadow_tags.size();
            case (req)
                REQ_ADD: begin
                    if (n >= DEPTH) begin
                        owe('0, 1'b0, 1'b1, RC_FULL);
                    end else begin
                        // position 0 or past the count means append
                        if (pos == 0 || int'(pos) - 1 >= n)
                            at = n;
                        else
                            at = int'(pos) - 1;
                        if (at == n)
                            shadow_tags.push_back(tag);
                        else
                            shadow_tags.insert(at, tag);
                        owe('0, 1'b0, 1'b1, RC_OK);
                    end
                end
                REQ_REMOVE: begin
                    if (n == 0) begin
                        owe('0, 1'b0, 1'b1, RC_EMPTY);
                    end else begin
                        owe(shadow_tags.pop_front(), 1'b1, 1'b1, RC_OK);
                    end
                end
                REQ_STATUS: begin
                    if (n == 0) begin
                        owe('0, 1'b0, 1'b1, RC_EMPTY);
                    end else begin
                        for (int i = 0; i < n; i++)
                            owe(shadow_tags[i], 1'b1, (i == n - 1), RC_OK);
                    end
                end
                default: ;  // unused code: no beat, no change
            endcase
        endfunction

        task check_result(input logic [PORT_TAG_W-1:0] tag, input logic valid,
                          input logic last, input logic [CODE_W-1:0] code);
            t_result_beat want;
            if (owed_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat tag=%h code=%0d",
                                          tag, code));
            end else begin
                want = owed_beats.pop_front();
                if (tag !== want.tag)
                    report_mismatch($sformatf("entry_tag %h, want %h", tag, want.tag));
                if (valid !== want.valid)
                    report_mismatch($sformatf("entry_valid %b, want %b",
                                              valid, want.valid));
                if (last !== want.last)
                    report_mismatch($sformatf("last_of_run %b, want %b",
                                              last, want.last));
                if (code !== want.code)
                    report_mismatch($sformatf("result_code %0d, want %0d",
                                              code, want.code));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and dut
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [REQ_W-1:0]      i_req_type = REQ_ADD;
    logic [PORT_TAG_W-1:0] i_item_tag = '0;
    logic [POS_W-1:0]      i_insert_position = '0;
    logic                  o_strobe;
    logic [PORT_TAG_W-1:0] o_entry_tag;
    logic                  o_entry_valid;
    logic                  o_last_of_run;
    logic [CODE_W-1:0]     o_result_code;

    tag_queue_scoreboard board = new();
    int unsigned         cycle_count = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    positional_insert_queue #(
        .QUEUE_DEPTH (DEPTH),
        .TAG_WIDTH   (PORT_TAG_W)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_req_type        (i_req_type),
        .i_item_tag        (i_item_tag),
        .i_insert_position (i_insert_position),
        .o_strobe          (o_strobe),
        .o_entry_tag       (o_entry_tag),
        .o_entry_valid     (o_entry_valid),
        .o_last_of_run     (o_last_of_run),
        .o_result_code     (o_result_code)
    );

    // result beats cannot be stalled, so every strobe is checked at its edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            board.check_result(o_entry_tag, o_entry_valid, o_last_of_run,
                               o_result_code);
    end

    // watchdog: a hung handshake or a lost beat ends the run here
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // request driver: inputs move on the falling edge, start stays high
    // until an edge with busy low takes the beat
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [REQ_W-1:0] req,
                                input logic [PORT_TAG_W-1:0] tag,
                                input logic [POS_W-1:0] pos);
        @(negedge i_clk);
        start             = 1'b1;
        i_req_type        = req;
        i_item_tag        = tag;
        i_insert_position = pos;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        board.note_request(req, tag, pos);
    endtask

    task automatic hold_off(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start = 1'b0;
        end
    endtask

    // stop sending and wait for every owed beat to show up
    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (board.owed_count() != 0)
            @(posedge i_clk);
    endtask

    // position mix: append, inside the current range, clamped, or anything
    function automatic logic [POS_W-1:0] pick_position();
        int n;
        n = board.stored_count();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return POS_W'($urandom_range(1, n + 1));
            2:       return POS_W'($urandom_range(n + 2, 255));
            default: return POS_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [PORT_TAG_W-1:0] pick_tag();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic             filling;
        int               phase_left;
        int               roll;
        logic [REQ_W-1:0] req;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty corners: status, remove and the no-op code on an empty queue
        send_request(REQ_STATUS, 32'h1234_5678, 8'd0);
        send_request(REQ_REMOVE, 32'hdead_beef, 8'd3);
        send_request(REQ_UNUSED, 32'hffff_ffff, 8'hff);

        // tail append, clamped position, head insert, middle insert
        send_request(REQ_ADD, 32'h0000_0000, 8'd0);
        send_request(REQ_ADD, 32'hffff_ffff, 8'd255);
        send_request(REQ_ADD, 32'ha5a5_a5a5, 8'd1);
        send_request(REQ_ADD, 32'h5a5a_5a5a, 8'd2);
        send_request(REQ_ADD, 32'h0f0f_f0f0, 8'd6);    // one past count -> append
        send_request(REQ_STATUS, 32'h0, 8'd0);
        send_request(REQ_REMOVE, 32'h0, 8'd0);
        send_request(REQ_UNUSED, 32'h0, 8'd1);          // no-op with a queue in place

        // fill up to depth, then hit the full case twice
        while (board.stored_count() < DEPTH)
            send_request(REQ_ADD, pick_tag(), pick_position());
        send_request(REQ_ADD, 32'hcafe_f00d, 8'd1);
        send_request(REQ_ADD, 32'h8000_0001, 8'd0);
        send_request(REQ_STATUS, 32'h0, 8'd0);
        send_request(REQ_REMOVE, 32'h0, 8'd0);

        // let everything drain before the random part starts
        wait_drained();

        // random traffic in alternating fill and drain phases
        filling    = 1'b1;
        phase_left = $urandom_range(15, 40);
        for (int k = 0; k < RANDOM_BEATS; k++) begin
            if (phase_left == 0) begin
                filling    = !filling;
                phase_left = $urandom_range(15, 40);
            end
            phase_left--;

            roll = $urandom_range(0, 99);
            if (roll < 4)
                req = REQ_UNUSED;
            else if (roll < 18)
                req = REQ_STATUS;
            else if (roll < (filling ? 76 : 38))
                req = REQ_ADD;
            else
                req = REQ_REMOVE;

            // sender gaps in bursts, none over the closing stretch
            if (k < RANDOM_BEATS - QUIET_TAIL && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 12));
            // one mid-run pause until the dut has nothing left to say
            if (k == RANDOM_BEATS / 2)
                wait_drained();

            send_request(req, pick_tag(), pick_position());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
